// File: src/mbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debouncer package
// Shared widths, reset values and types of the multi-button debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

	localparam int NUM_BUTTONS = 5;
	localparam int CNT_W       = 8;
	localparam int TICK_W      = 32;

	localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(4);

	typedef logic [NUM_BUTTONS-1:0] button_vec_t;
	typedef logic [CNT_W-1:0]       run_cnt_t;
	typedef logic [TICK_W-1:0]      tick_t;

	// What one lane reports after a tick.
	typedef struct packed {
		logic held;
		logic pending;
	} lane_status_t;

	typedef lane_status_t [NUM_BUTTONS-1:0] lane_status_vec_t;

endpackage

// File: src/mbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debouncer channel interfaces
// Valid/ready channels for input samples and result items.
// ----------------------------------------------------------------------------
interface mbd_sample_if;
	logic                 valid;
	logic                 ready;
	mbd_pkg::button_vec_t pin_levels;
	mbd_pkg::button_vec_t ack_mask;

	modport source (output valid, output pin_levels, output ack_mask, input ready);
	modport sink   (input valid, input pin_levels, input ack_mask, output ready);
endinterface

interface mbd_status_if;
	logic                 valid;
	logic                 ready;
	mbd_pkg::button_vec_t pressed_events;
	mbd_pkg::button_vec_t held_buttons;
	mbd_pkg::tick_t       tick_count;

	modport source (output valid, output pressed_events, output held_buttons,
		output tick_count, input ready);
	modport sink   (input valid, input pressed_events, input held_buttons,
		input tick_count, output ready);
endinterface

// File: src/mbd_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debouncer lane
// Run counters, held flag and sticky press event of a single button.
// ----------------------------------------------------------------------------
module mbd_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  level,
	input  logic                  ack,
	input  mbd_pkg::run_cnt_t     count,
	output mbd_pkg::lane_status_t status_next
);

	mbd_pkg::run_cnt_t high_run_q, low_run_q;
	mbd_pkg::run_cnt_t high_run_d, low_run_d;
	mbd_pkg::run_cnt_t high_inc, low_inc;
	logic              held_q, pending_q;
	logic              held_d, pending_d;

	assign high_inc = high_run_q + mbd_pkg::CNT_W'(1);
	assign low_inc  = low_run_q + mbd_pkg::CNT_W'(1);

	always_comb begin
		high_run_d = high_run_q;
		low_run_d  = low_run_q;
		held_d     = held_q;
		pending_d  = pending_q & ~ack;
		if (level) begin
			// Runs saturate at the count; reaching it releases the button.
			if (high_run_q < count) begin
				high_run_d = high_inc;
				if (high_inc >= count) begin
					held_d = 1'b0;
				end
			end
			low_run_d = '0;
		end else begin
			if (low_run_q < count) begin
				low_run_d = low_inc;
				if (low_inc >= count && !held_q) begin
					held_d    = 1'b1;
					pending_d = 1'b1;
				end
			end
			high_run_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_run_q <= '0;
			low_run_q  <= '0;
			held_q     <= 1'b0;
			pending_q  <= 1'b0;
		end else if (en) begin
			high_run_q <= high_run_d;
			low_run_q  <= low_run_d;
			held_q     <= held_d;
			pending_q  <= pending_d;
		end
	end

	assign status_next.held    = held_d;
	assign status_next.pending = pending_d;

endmodule

// File: src/mbd_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debouncer merge stage
// Gathers the lane results and the tick count into the output register.
// ----------------------------------------------------------------------------
module mbd_merge (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  mbd_pkg::lane_status_vec_t lanes,
	input  mbd_pkg::tick_t            tick_next,
	output logic                      take_ok,
	mbd_status_if.source              status
);

	mbd_pkg::button_vec_t pressed_d, held_d;
	mbd_pkg::button_vec_t pressed_s1, held_s1;
	mbd_pkg::tick_t       tick_s1;
	logic                 valid_s1;

	always_comb begin
		for (int i = 0; i < mbd_pkg::NUM_BUTTONS; i++) begin
			pressed_d[i] = lanes[i].pending;
			held_d[i]    = lanes[i].held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= 1'b1;
		end else if (status.ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pressed_s1 <= pressed_d;
			held_s1    <= held_d;
			tick_s1    <= tick_next;
		end
	end

	// A new item may enter when the register is empty or drains this cycle.
	assign take_ok = !valid_s1 || status.ready;

	assign status.valid          = valid_s1;
	assign status.pressed_events = pressed_s1;
	assign status.held_buttons   = held_s1;
	assign status.tick_count     = tick_s1;

endmodule

// File: src/multi_button_debouncer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-button debouncer
// Counter-based debouncing of active-low buttons with sticky press events.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                  Transfer when
//  sample    in         pin_levels, ack_mask                     valid & ready
//  status    out        pressed_events, held_buttons, tick_count valid & ready
//  cfg       in         cfg_wr_data (debounce count)             cfg_wr_en
//
// The lanes update on the transfer edge and the result lands in the output
// register on that same edge, which drives the status port. A new sample is
// taken every cycle; the only limit is the output register, which takes one
// while it is empty or being drained. Reset clears all run counters, flags,
// events and the tick counter and sets the debounce count to four. A stall on
// status holds sample.ready low.
//
// One lane per button holds that button's run counters, held flag and
// pending event. The merge stage packs the lane results and the advanced
// tick count into the output register.
// ----------------------------------------------------------------------------
module multi_button_debouncer_unit (
	input  logic              clk,
	input  logic              arst_n,
	mbd_sample_if.sink        sample,
	mbd_status_if.source      status,
	input  logic              cfg_wr_en,
	input  mbd_pkg::run_cnt_t cfg_wr_data
);

	mbd_pkg::run_cnt_t         count_q;
	mbd_pkg::tick_t            tick_q;
	mbd_pkg::tick_t            tick_next;
	mbd_pkg::lane_status_vec_t lane_next;
	logic                      take_ok;
	logic                      fire;

	assign sample.ready = take_ok;
	assign fire         = sample.valid && take_ok;

	// The user must write the debounce count only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= mbd_pkg::DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	// The tick counter wraps naturally at its full width.
	assign tick_next = tick_q + mbd_pkg::TICK_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (fire) begin
			tick_q <= tick_next;
		end
	end

	// One lane per button; acknowledges are applied inside each lane before
	// the new level is examined, so a press on the same tick stays pending.
	for (genvar g = 0; g < mbd_pkg::NUM_BUTTONS; g++) begin : g_lane
		mbd_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (fire),
			.level       (sample.pin_levels[g]),
			.ack         (sample.ack_mask[g]),
			.count       (count_q),
			.status_next (lane_next[g])
		);
	end

	mbd_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (fire),
		.lanes     (lane_next),
		.tick_next (tick_next),
		.take_ok   (take_ok),
		.status    (status)
	);

	// Every accepted sample produces a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> status.valid)
		else $error("accepted sample produced no result");

	// The result carries the advanced tick count.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> status.tick_count == tick_q)
		else $error("result tick count does not match tick counter");

	// The tick counter moves only on a sample transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> tick_q == $past(tick_q))
		else $error("tick counter moved without a transfer");

endmodule

// File: tb/sv/multi_button_debouncer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-button debouncer testbench
// Drives button samples through the valid/ready sample channel. A cycle-true
// software copy of the debouncer predicts every status transfer, and each
// transfer is checked field by field. Directed cases come first. Random run
// patterns follow over several debounce counts, under random idling and
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module multi_button_debouncer_unit_tb;

	localparam int CLK_PERIOD  = 10;
	localparam int CYCLE_LIMIT = 100000;
	localparam int IDLE_PCT    = 34;
	localparam int MAX_REPORTS = 10;

	// One predicted status transfer.
	typedef struct {
		mbd_pkg::button_vec_t events;
		mbd_pkg::button_vec_t held;
		mbd_pkg::tick_t       ticks;
	} status_rec_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	mbd_pkg::run_cnt_t cfg_wr_data;

	mbd_sample_if sample_ch ();
	mbd_status_if status_ch ();

	multi_button_debouncer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample_ch),
		.status      (status_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Software copy of the debouncer state. It only moves when a sample
	// transfer is seen, so it stays in step with the hardware.
	mbd_pkg::run_cnt_t    up_run [mbd_pkg::NUM_BUTTONS];
	mbd_pkg::run_cnt_t    down_run [mbd_pkg::NUM_BUTTONS];
	mbd_pkg::button_vec_t held_now;
	mbd_pkg::button_vec_t events_now;
	mbd_pkg::tick_t       ticks_now;
	mbd_pkg::run_cnt_t    debounce_len;

	status_rec_t predicted_status [$];

	int  fail_count;
	int  cycle_count;
	int  press_total;
	int  release_total;
	int  cfg_writes;
	int  hold_off_len;
	bit  no_idle;

	// Random run shaping: each button follows a target level for a run of
	// random length, with optional bounce noise on top.
	mbd_pkg::button_vec_t run_target;
	int                   run_left [mbd_pkg::NUM_BUTTONS];

	// ------------------------------------------------------------------
	// Clock, reset and the cycle limit
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor: one debounce tick for one accepted sample
	// ------------------------------------------------------------------
	function automatic void debounce_tick(mbd_pkg::button_vec_t levels,
		mbd_pkg::button_vec_t ack);
		status_rec_t rec;
		// The acknowledge comes first, so an event latched on this very tick
		// survives an acknowledge of the same button.
		events_now = events_now & ~ack;
		ticks_now  = ticks_now + 1;
		for (int b = 0; b < mbd_pkg::NUM_BUTTONS; b++) begin
			if (levels[b]) begin
				// Released level: grow the high run up to the count. A run
				// already at or above a lowered count neither grows nor
				// releases the button.
				if (up_run[b] < debounce_len) begin
					up_run[b] = up_run[b] + 1'b1;
					if (up_run[b] >= debounce_len && held_now[b]) begin
						held_now[b] = 1'b0;
						release_total++;
					end
				end
				down_run[b] = '0;
			end else begin
				// Pressed level: a button that is already held latches no
				// second event when its low run reaches the count again.
				if (down_run[b] < debounce_len) begin
					down_run[b] = down_run[b] + 1'b1;
					if (down_run[b] >= debounce_len && !held_now[b]) begin
						held_now[b]   = 1'b1;
						events_now[b] = 1'b1;
						press_total++;
					end
				end
				up_run[b] = '0;
			end
		end
		rec.events = events_now;
		rec.held   = held_now;
		rec.ticks  = ticks_now;
		predicted_status.push_back(rec);
	endfunction

	// ------------------------------------------------------------------
	// Status checker: every status transfer against the oldest prediction
	// ------------------------------------------------------------------
	function automatic void note_mismatch(string what, longint unsigned want_v,
		longint unsigned got_v);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("MISMATCH at cycle %0d: %s expected 0x%0h, got 0x%0h",
				cycle_count, what, want_v, got_v);
	endfunction

	always @(posedge clk) begin : check_status
		status_rec_t want;
		if (arst_n && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
			if (predicted_status.size() == 0) begin
				note_mismatch("unexpected status transfer, tick_count", 0,
					status_ch.tick_count);
			end else begin
				want = predicted_status.pop_front();
				if (status_ch.pressed_events !== want.events)
					note_mismatch("pressed_events", want.events, status_ch.pressed_events);
				if (status_ch.held_buttons !== want.held)
					note_mismatch("held_buttons", want.held, status_ch.held_buttons);
				if (status_ch.tick_count !== want.ticks)
					note_mismatch("tick_count", want.ticks, status_ch.tick_count);
			end
		end
	end

	// ------------------------------------------------------------------
	// Status receiver. Random stalls, except during a no-idle stretch. A
	// requested hold-off keeps ready low while hold_off_len counts down here,
	// so the output register fills and the sample channel stalls.
	// ------------------------------------------------------------------
	initial begin
		status_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_off_len > 0) begin
				status_ch.ready = 1'b0;
				hold_off_len--;
			end else if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
				status_ch.ready = 1'b0;
			end else begin
				status_ch.ready = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sample sender and shared helpers
	// ------------------------------------------------------------------

	// Offers one sample and returns at the edge of its transfer. Random gaps
	// are inserted before the offer; valid stays high between back-to-back
	// samples, so it is never lowered and raised in one time step.
	task automatic send_sample(mbd_pkg::button_vec_t levels, mbd_pkg::button_vec_t ack);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid = 1'b0;
			@(negedge clk);
		end
		sample_ch.valid      = 1'b1;
		sample_ch.pin_levels = levels;
		sample_ch.ack_mask   = ack;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		debounce_tick(levels, ack);
	endtask

	// Stops offering samples and waits until every predicted status has been
	// seen. Every sample yields a status, so the block is idle afterwards.
	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (predicted_status.size() != 0)
			@(negedge clk);
	endtask

	// The debounce count is only changed while the block is idle.
	task automatic write_debounce(mbd_pkg::run_cnt_t value);
		drain_results();
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en    = 1'b0;
		debounce_len = value;
		cfg_writes++;
	endtask

	// Sends samples whose per-button levels follow runs of random length,
	// flipped by bounce noise at the given rate. Acknowledges are random.
	task automatic send_runs(int n_items, int run_lo, int run_hi, int bounce_pct);
		mbd_pkg::button_vec_t levels;
		mbd_pkg::button_vec_t ack;
		for (int n = 0; n < n_items; n++) begin
			for (int b = 0; b < mbd_pkg::NUM_BUTTONS; b++) begin
				if (run_left[b] <= 0) begin
					run_target[b] = ~run_target[b];
					run_left[b]   = $urandom_range(run_hi, run_lo);
				end
				run_left[b]--;
				levels[b] = run_target[b] ^ ($urandom_range(99) < bounce_pct);
			end
			ack = ($urandom_range(99) < 30) ? mbd_pkg::button_vec_t'($urandom) : '0;
			send_sample(levels, ack);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// With the reset count of four, all buttons go down together, are
	// acknowledged and then come back up.
	task automatic test_press_and_release();
		repeat (4) send_sample('0, '0);
		send_sample('1, '1);
		repeat (3) send_sample('1, '0);
	endtask

	// The acknowledge lands on the tick that latches the press, so the new
	// events must stay pending.
	task automatic test_ack_on_press_tick();
		repeat (3) send_sample('0, '0);
		send_sample('0, '1);
	endtask

	// Three of the five buttons blip up for one tick, too short to release
	// them. Their low runs then reach the count again while still held: no new event.
	task automatic test_repeated_press();
		send_sample(5'b10101, '1);
		repeat (4) send_sample('0, '0);
	endtask

	// High runs of three, then the count is lowered to two. The runs above
	// the new count must not release; a fresh run of two must.
	task automatic test_lowered_count();
		repeat (3) send_sample('1, '0);
		write_debounce(8'd2);
		send_sample('1, '0);
		send_sample('0, '0);
		repeat (2) send_sample('1, '0);
	endtask

	// A zero count freezes held flags and events; only acknowledges still
	// clear events.
	task automatic test_zero_count();
		repeat (2) send_sample(5'b11001, '0);
		write_debounce(8'd0);
		send_sample('1, '0);
		send_sample('0, '0);
		send_sample('1, '0);
		send_sample('0, '1);
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering samples back to back, then the sender pauses until all
	// results are in.
	task automatic test_backpressure();
		write_debounce(8'd3);
		hold_off_len = 300;
		no_idle      = 1'b1;
		send_runs(40, 1, 6, 10);
		no_idle = 1'b0;
		drain_results();
	endtask

	// Random runs over several counts, from one up to the largest.
	task automatic test_random_settings();
		write_debounce(8'd4);
		send_runs(100, 2, 10, 10);

		// Single-tick debounce with no idling on either side.
		write_debounce(8'd1);
		no_idle = 1'b1;
		send_runs(100, 1, 4, 20);
		no_idle = 1'b0;

		// The largest count needs long clean runs; some fall just short.
		write_debounce(8'd255);
		send_runs(460, 240, 300, 0);

		repeat (2) begin
			write_debounce(mbd_pkg::run_cnt_t'($urandom_range(12, 2)));
			send_runs(60, 1, 16, 15);
		end

		// Mostly noise.
		write_debounce(8'd1);
		send_runs(30, 1, 1, 50);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_wr_data          = '0;
		sample_ch.valid      = 1'b0;
		sample_ch.pin_levels = '0;
		sample_ch.ack_mask   = '0;
		fail_count           = 0;
		cycle_count          = 0;
		press_total          = 0;
		release_total        = 0;
		cfg_writes           = 0;
		hold_off_len         = 0;
		no_idle              = 1'b0;
		run_target           = '1;
		held_now             = '0;
		events_now           = '0;
		ticks_now            = '0;
		debounce_len         = mbd_pkg::DEBOUNCE_RESET;
		for (int b = 0; b < mbd_pkg::NUM_BUTTONS; b++) begin
			up_run[b]   = '0;
			down_run[b] = '0;
			run_left[b] = 0;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_press_and_release();
		test_ack_on_press_tick();
		test_repeated_press();
		test_lowered_count();
		test_zero_count();
		test_backpressure();
		test_random_settings();

		drain_results();
		repeat (4) @(negedge clk);

		if (predicted_status.size() != 0) begin
			$display("ERROR: %0d predicted results never arrived", predicted_status.size());
			fail_count += predicted_status.size();
		end

		$display("Covered %0d ticks across %0d debounce count writes (0, 1 and 255 included).",
			ticks_now, cfg_writes);
		$display("Saw %0d debounced presses and %0d releases; %0d mismatches.",
			press_total, release_total, fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: multi_button_debouncer_unit.f
src/mbd_pkg.sv
src/mbd_if.sv
src/mbd_lane.sv
src/mbd_merge.sv
src/multi_button_debouncer_unit.sv
tb/sv/multi_button_debouncer_unit_tb.sv
